### sv/hrp_pkg.sv
`default_nettype none

package hrp_pkg;

	// characters with a meaning of their own
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// line layout: data, segment and EOF checksum digits start here
	localparam logic [9:0] DATA_START = 10'd9;
	localparam logic [9:0] POS_MAX    = 10'd1023;

	localparam logic [7:0] TYPE_DATA = 8'd0;
	localparam logic [7:0] TYPE_EOF  = 8'd1;
	localparam logic [7:0] TYPE_SEG  = 8'd2;
	localparam logic [7:0] MAX_TYPE  = 8'd2;

	// result kinds
	localparam logic [2:0] KIND_DATA      = 3'd0;
	localparam logic [2:0] KIND_DONE      = 3'd1;
	localparam logic [2:0] KIND_BAD_START = 3'd2;
	localparam logic [2:0] KIND_BAD_TYPE  = 3'd3;
	localparam logic [2:0] KIND_SHORT     = 3'd4;

	typedef enum logic [1:0] {
		PH_LINE_START,
		PH_RECORD,
		PH_SKIP
	} phase_t;

	// classified character
	typedef struct packed {
		logic       is_colon;
		logic       is_cr;
		logic       is_lf;
		logic [3:0] digit;
	} tok_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] record_address;
		logic [7:0]  byte_index;
		logic [7:0]  data_value;
		logic [7:0]  byte_count;
		logic [7:0]  record_type;
		logic [19:0] extended_address;
		logic [7:0]  checksum;
	} res_t;

	// non-hex characters decode as zero
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] t;
		t = 8'h00;
		if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h46) begin
			t = c - 8'h37;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			t = c - 8'h57;
		end
		return t[3:0];
	endfunction

	function automatic tok_t classify(input logic [7:0] c);
		tok_t t;
		t.is_colon = (c == CH_COLON);
		t.is_cr    = (c == CH_CR);
		t.is_lf    = (c == CH_LF);
		t.digit    = hex_val(c);
		return t;
	endfunction

endpackage

`default_nettype wire

### sv/hex_record_parser.sv
// Flow: a character accepted by the front end is registered in the token queue;
// the record state machine takes the tokens in order while the result queue has
// room; a result is registered there and shows on the result ports (empty low).
// Throughput: one character per cycle while the result queue has room; full
// rises only when the result queue backs up into the tokens.
// Reset (arst_n low, asynchronous): both queues empty, line-start phase, halt
// cleared. Any error result halts the parser until the next reset.
`default_nettype none

module hex_record_parser #(
	parameter int TOK_DEPTH = 4,   // token queue between front and back, >= 2
	parameter int OUT_DEPTH = 2    // result queue, >= 2
) (
	input  wire         clk,
	input  wire         arst_n,

	// character side: one word is one ASCII character
	input  wire         push,
	output logic        full,
	input  wire  [7:0]  char_in,

	// result side
	output logic        empty,
	input  wire         pop,
	output logic [2:0]  kind,
	output logic [15:0] record_address,
	output logic [7:0]  byte_index,
	output logic [7:0]  data_value,
	output logic [7:0]  byte_count,
	output logic [7:0]  record_type,
	output logic [19:0] extended_address,
	output logic [7:0]  checksum
);

	// front -> back token channel
	logic          tok_valid;
	logic          tok_pop;
	hrp_pkg::tok_t tok;

	// back -> result queue
	logic          res_valid;
	logic          out_full;
	hrp_pkg::res_t res;
	hrp_pkg::res_t head;

	// Front end: classifies each character (colon, CR, LF, hex digit value)
	// as it is written, so the back end never decodes raw ASCII.
	hrp_front #(
		.DEPTH (TOK_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.char_in   (char_in),
		.full      (full),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop)
	);

	// Back end: line/record state machine. It takes a token only when the
	// result queue has room, so a result is never dropped; tokens that make
	// no result are held back too while the result queue is full.
	hrp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.tok_pop   (tok_pop),
		.out_full  (out_full),
		.res_valid (res_valid),
		.res       (res)
	);

	// Result queue: parts the state machine from the consumer, so a waiting
	// result does not stop new characters from being decoded.
	hrp_outq #(
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res),
		.full    (out_full),
		.empty   (empty),
		.pop     (pop),
		.rd_data (head)
	);

	assign kind             = head.kind;
	assign record_address   = head.record_address;
	assign byte_index       = head.byte_index;
	assign data_value       = head.data_value;
	assign byte_count       = head.byte_count;
	assign record_type      = head.record_type;
	assign extended_address = head.extended_address;
	assign checksum         = head.checksum;

endmodule

`default_nettype wire

### sv/hrp_front.sv
`default_nettype none

// accepts characters, classifies them, holds them in a short token queue
module hrp_front #(
	parameter int DEPTH = 4
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire  [7:0]          char_in,
	output logic                full,
	output logic                tok_valid,
	output hrp_pkg::tok_t       tok,
	input  wire                 tok_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hrp_pkg::tok_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr;
	logic             rd;

	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign tok_valid = (cnt_q != '0);
	assign tok       = mem_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = tok_pop && tok_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= hrp_pkg::classify(char_in);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_pop_needs_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_pop |-> tok_valid)
		else $error("token popped from empty queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("token queue count overrun");

	a_cnt_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(wr && !rd) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("token queue count lost a word");

endmodule

`default_nettype wire

### sv/hrp_back.sv
`default_nettype none

// record state machine: one token per cycle unless out_full, at most one result each
module hrp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 tok_valid,
	input  hrp_pkg::tok_t       tok,
	output logic                tok_pop,
	input  wire                 out_full,
	output logic                res_valid,
	output hrp_pkg::res_t       res
);

	hrp_pkg::phase_t phase_q, phase_d;
	logic        halted_q, halted_d;
	logic [9:0]  pos_q, pos_d;
	logic [3:0]  hn_q, hn_d;
	logic [7:0]  len_q, len_d;
	logic [15:0] addr_q, addr_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] seg_q, seg_d;
	logic [7:0]  ck_q, ck_d;

	logic        fire;
	logic [9:0]  data_end;
	logic [9:0]  ckpos;
	logic [9:0]  rel;
	logic [8:0]  rel_byte;

	assign fire     = tok_valid && !out_full;
	assign tok_pop  = fire;
	assign data_end = hrp_pkg::DATA_START + {1'b0, len_q, 1'b0};
	assign ckpos    = (type_q == hrp_pkg::TYPE_EOF) ? hrp_pkg::DATA_START : data_end;
	assign rel      = pos_q - hrp_pkg::DATA_START;
	assign rel_byte = rel[9:1];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (fire && !halted_q) begin
			unique case (phase_q)
				hrp_pkg::PH_LINE_START: begin
					if (tok.is_colon) begin
						phase_d = hrp_pkg::PH_RECORD;
					end else if (tok.is_cr) begin
						phase_d = hrp_pkg::PH_SKIP;
					end
				end
				hrp_pkg::PH_RECORD: begin
					if (tok.is_lf) begin
						phase_d = hrp_pkg::PH_LINE_START;
					end
				end
				hrp_pkg::PH_SKIP: begin
					if (tok.is_lf) begin
						phase_d = hrp_pkg::PH_LINE_START;
					end
				end
				default: phase_d = hrp_pkg::PH_LINE_START;
			endcase
		end
	end

	// field updates and result
	always_comb begin
		halted_d  = halted_q;
		pos_d     = pos_q;
		hn_d      = hn_q;
		len_d     = len_q;
		addr_d    = addr_q;
		type_d    = type_q;
		seg_d     = seg_q;
		ck_d      = ck_q;
		res_valid = 1'b0;
		res       = '0;
		res.record_address = addr_q;
		res.byte_count     = len_q;
		res.record_type    = type_q;
		if (fire && !halted_q) begin
			unique case (phase_q)
				hrp_pkg::PH_LINE_START: begin
					pos_d  = '0;
					hn_d   = '0;
					len_d  = '0;
					addr_d = '0;
					type_d = '0;
					seg_d  = '0;
					ck_d   = '0;
					if (tok.is_colon) begin
						pos_d = 10'd1;
					end else if (!tok.is_cr) begin
						res_valid = 1'b1;
						res       = '0;
						res.kind  = hrp_pkg::KIND_BAD_START;
						halted_d  = 1'b1;
					end
				end
				hrp_pkg::PH_RECORD: begin
					if (tok.is_lf) begin
						res_valid = 1'b1;
						if (type_q > hrp_pkg::MAX_TYPE) begin
							res.kind = hrp_pkg::KIND_BAD_TYPE;
							halted_d = 1'b1;
						end else if (type_q == hrp_pkg::TYPE_DATA && pos_q < data_end) begin
							res.kind = hrp_pkg::KIND_SHORT;
							halted_d = 1'b1;
						end else begin
							res.kind     = hrp_pkg::KIND_DONE;
							res.checksum = ck_q;
							if (type_q == hrp_pkg::TYPE_SEG) begin
								res.extended_address = {seg_q, 4'h0};
							end
						end
					end else if (pos_q != hrp_pkg::POS_MAX) begin
						pos_d = pos_q + 10'd1;
						case (pos_q)
							10'd1: len_d[7:4] = tok.digit;
							10'd2: len_d[3:0] = tok.digit;
							10'd3: addr_d[15:12] = tok.digit;
							10'd4: addr_d[11:8] = tok.digit;
							10'd5: addr_d[7:4] = tok.digit;
							10'd6: addr_d[3:0] = tok.digit;
							10'd7: type_d[7:4] = tok.digit;
							10'd8: type_d[3:0] = tok.digit;
							default: ;
						endcase
						if (pos_q >= hrp_pkg::DATA_START) begin
							// segment digits sit at fixed positions 9..12
							if (type_q == hrp_pkg::TYPE_SEG) begin
								case (pos_q)
									10'd9:  seg_d[15:12] = tok.digit;
									10'd10: seg_d[11:8] = tok.digit;
									10'd11: seg_d[7:4] = tok.digit;
									10'd12: seg_d[3:0] = tok.digit;
									default: ;
								endcase
							end
							if (pos_q == ckpos) begin
								ck_d = {tok.digit, 4'h0};
							end else if (pos_q == ckpos + 10'd1) begin
								ck_d[3:0] = tok.digit;
							end
							if (type_q == hrp_pkg::TYPE_DATA && rel_byte < {1'b0, len_q}) begin
								if (!rel[0]) begin
									hn_d = tok.digit;
								end else begin
									res_valid      = 1'b1;
									res.kind       = hrp_pkg::KIND_DATA;
									res.byte_index = rel_byte[7:0];
									res.data_value = {hn_q, tok.digit};
								end
							end
						end
					end
				end
				hrp_pkg::PH_SKIP: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hrp_pkg::PH_LINE_START;
			halted_q <= 1'b0;
			pos_q    <= '0;
			hn_q     <= '0;
			len_q    <= '0;
			addr_q   <= '0;
			type_q   <= '0;
			seg_q    <= '0;
			ck_q     <= '0;
		end else begin
			phase_q  <= phase_d;
			halted_q <= halted_d;
			pos_q    <= pos_d;
			hn_q     <= hn_d;
			len_q    <= len_d;
			addr_q   <= addr_d;
			type_q   <= type_d;
			seg_q    <= seg_d;
			ck_q     <= ck_d;
		end
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt released without reset");

	a_no_result_halted: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |-> !res_valid)
		else $error("result while halted");

	a_result_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (tok_pop && !out_full))
		else $error("result without a consumed token or queue room");

	a_data_in_record: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.kind == hrp_pkg::KIND_DATA) |->
			(phase_q == hrp_pkg::PH_RECORD && type_q == hrp_pkg::TYPE_DATA))
		else $error("data byte outside a data record");

endmodule

`default_nettype wire

### sv/hrp_outq.sv
`default_nettype none

// result queue seen by the consumer as empty/pop
module hrp_outq #(
	parameter int DEPTH = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 wr_en,
	input  hrp_pkg::res_t       wr_data,
	output logic                full,
	output logic                empty,
	input  wire                 pop,
	output hrp_pkg::res_t       rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hrp_pkg::res_t    mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             wr;
	logic             rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];
	assign wr      = wr_en && !full;
	assign rd      = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full)
		else $error("result written into full queue");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("result queue count overrun");

	a_cnt_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(rd && !wr) |=> (cnt_q == $past(cnt_q) - 1'b1))
		else $error("result queue count lost a pop");

endmodule

`default_nettype wire
